// ===== src/pflru_pkg.sv =====
// ----------------------------------------------------------------------------
// pflru_pkg
// Shared types and constants for the page frame replacement engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pflru_pkg;
  localparam int FRAMES = 16;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_INSTALL = 2'd1;
  localparam logic [1:0] OP_CKPT = 2'd2;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_ALL_DIRTY = 3'd2;
  localparam logic [2:0] ST_WRITE_BACK = 3'd3;
  localparam logic [2:0] ST_CKPT_DONE = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] page_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [31:0] result_page_id;
    logic        last;
  } out_word_t;

  // command to one recency slot
  typedef struct packed {
    logic          shift;
    logic [FW-1:0] front;
  } slot_ctl_t;
endpackage
`default_nettype wire

// ===== src/page_frame_lru_with_dirty_pinning.sv =====
// ----------------------------------------------------------------------------
// page_frame_lru_with_dirty_pinning
// Tag and recency engine for a page buffer pool with dirty frame pinning.
// ----------------------------------------------------------------------------
// A read or install runs in steps up to its single result word: first
// compare all tags and pick the victim, then shift the recency chain of
// cells and emit the word. A checkpoint walks the chain one slot a cycle,
// emitting a write back word per dirty frame and then a done word. busy
// is high while an item is at work; the receiver cannot stall, each word
// shows for one cycle under out_valid.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_lru_with_dirty_pinning (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  pflru_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output pflru_pkg::out_word_t out_word
);
  import pflru_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [FRAMES-1:0] valid_r, dirty_r;
  logic [31:0] page_r [FRAMES];
  logic [FW-1:0] ord [FRAMES];
  slot_ctl_t ctl [FRAMES];

  logic          op_inst_r;
  logic [31:0]   pid_r;
  logic          hit_r, none_r;
  logic [FW-1:0] frame_r;
  logic [FW:0]   wp_r;
  out_word_t     ow_r;
  logic          ov_r;

  // position of the touched frame in the recency chain
  logic [FW-1:0] pos_c;
  always_comb begin
    pos_c = '0;
    for (int p = 0; p < FRAMES; p++) begin
      if (ord[p] == frame_r) pos_c = FW'(p);
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word = ow_r;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_slot
      pflru_slot u_slot (
        .clk(clk), .rst_n(rst_n), .init_val(FW'(g)), .is_head(g == 0),
        .prev_val(ord[(g == 0) ? 0 : g - 1]), .ctl(ctl[g]), .val(ord[g]));
      always_comb begin
        ctl[g].front = frame_r;
        ctl[g].shift = (state_r == S_UPD) && !none_r && (FW'(g) <= pos_c);
      end
    end
  endgenerate

  // lookup and victim search
  logic          hit_c, vic_ok_c;
  logic [FW-1:0] hit_f_c, vic_c;
  always_comb begin
    hit_c = 1'b0; hit_f_c = '0; vic_ok_c = 1'b0; vic_c = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!hit_c && valid_r[i] && page_r[i] == in_word.page_id) begin
        hit_c = 1'b1; hit_f_c = FW'(i);
      end
    end
    for (int p = 0; p < FRAMES; p++) begin
      if (!dirty_r[ord[p]]) begin
        vic_ok_c = 1'b1; vic_c = ord[p];
      end
    end
  end

  logic [FW-1:0] wf;
  assign wf = ord[wp_r[FW-1:0]];

  logic evict_c;
  assign evict_c = !none_r && !hit_r && valid_r[frame_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      ov_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          ov_r <= 1'b0;
          if (start) begin
            op_inst_r <= (in_word.op == OP_INSTALL);
            pid_r <= in_word.page_id;
            if (in_word.op == OP_READ || in_word.op == OP_INSTALL) begin
              hit_r <= hit_c;
              none_r <= !hit_c && !vic_ok_c;
              frame_r <= hit_c ? hit_f_c : vic_c;
              state_r <= S_UPD;
            end else if (in_word.op == OP_CKPT) begin
              wp_r <= '0;
              state_r <= S_WALK;
            end
          end
        end
        S_UPD: begin
          state_r <= S_IDLE;
          ov_r <= 1'b1;
          ow_r.last <= 1'b1;
          ow_r.status <= none_r ? ST_ALL_DIRTY : (hit_r ? ST_HIT : ST_MISS);
          ow_r.frame_index <= none_r ? 4'd0 : 4'(frame_r);
          ow_r.evicted_valid <= evict_c;
          ow_r.result_page_id <= evict_c ? page_r[frame_r] : 32'd0;
          if (!none_r) begin
            if (hit_r) begin
              if (op_inst_r) dirty_r[frame_r] <= 1'b1;
            end else begin
              page_r[frame_r] <= pid_r;
              valid_r[frame_r] <= 1'b1;
              dirty_r[frame_r] <= op_inst_r;
            end
          end
        end
        S_WALK: begin
          ov_r <= dirty_r[wf];
          if (dirty_r[wf]) begin
            ow_r.status <= ST_WRITE_BACK;
            ow_r.frame_index <= 4'(wf);
            ow_r.evicted_valid <= 1'b0;
            ow_r.result_page_id <= page_r[wf];
            ow_r.last <= 1'b0;
          end
          if (wp_r == (FW+1)'(FRAMES - 1)) state_r <= S_DONE;
          wp_r <= wp_r + 1'b1;
        end
        S_DONE: begin
          ov_r <= 1'b1;
          ow_r.status <= ST_CKPT_DONE;
          ow_r.frame_index <= '0;
          ow_r.evicted_valid <= 1'b0;
          ow_r.result_page_id <= '0;
          ow_r.last <= 1'b1;
          dirty_r <= '0;
          state_r <= S_IDLE;
        end
        default: begin
          ov_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/pflru_slot.sv =====
// ----------------------------------------------------------------------------
// pflru_slot
// One recency cell: holds a frame index, takes the neighbor's index on shift, or the front frame if it is the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pflru_slot (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire [pflru_pkg::FW-1:0] init_val,
  input  wire                     is_head,
  input  wire [pflru_pkg::FW-1:0] prev_val,
  input  pflru_pkg::slot_ctl_t    ctl,
  output logic [pflru_pkg::FW-1:0] val
);
  import pflru_pkg::*;
  logic [FW-1:0] val_r;
  assign val = val_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= init_val;
    end else if (ctl.shift) begin
      val_r <= is_head ? ctl.front : prev_val;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_page_frame_lru_with_dirty_pinning.sv =====
// ----------------------------------------------------------------------------
// tb_page_frame_lru_with_dirty_pinning
// Self-checking bench for the page frame replacement engine: a built-in
// predictor of tags, dirty pins and recency order forecasts every result
// word, which a monitor compares field by field as words come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_page_frame_lru_with_dirty_pinning;
  import pflru_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;

  always #10 clk = ~clk;

  page_frame_lru_with_dirty_pinning i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  // predictor state
  logic          pool_valid [FRAMES];
  logic          pool_dirty [FRAMES];
  logic [31:0]   pool_page [FRAMES];
  int            pool_order [FRAMES];
  out_word_t     pending_words[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  bit            gap_free = 1'b0;
  logic [31:0]   page_pool[$];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic pool_reset();
    for (int i = 0; i < FRAMES; i++) begin
      pool_valid[i] = 1'b0;
      pool_dirty[i] = 1'b0;
      pool_page[i] = '0;
      pool_order[i] = i;
    end
  endtask

  function automatic void promote_frame(input int f);
    int p;
    p = 0;
    while (p < FRAMES && pool_order[p] != f) p++;
    while (p > 0) begin
      pool_order[p] = pool_order[p - 1];
      p--;
    end
    pool_order[0] = f;
  endfunction

  function automatic out_word_t make_word(input logic [2:0] st, input int f,
                                          input logic ev, input logic [31:0] pid,
                                          input logic lst);
    out_word_t w;
    w.status = st;
    w.frame_index = f[3:0];
    w.evicted_valid = ev;
    w.result_page_id = pid;
    w.last = lst;
    return w;
  endfunction

  function automatic void predict_pool(input in_word_t w);
    int f;
    f = -1;
    if (w.op == OP_READ || w.op == OP_INSTALL) begin
      for (int i = 0; i < FRAMES; i++)
        if (f < 0 && pool_valid[i] && pool_page[i] == w.page_id) f = i;
      if (f >= 0) begin
        if (w.op == OP_INSTALL) pool_dirty[f] = 1'b1;
        promote_frame(f);
        pending_words.push_back(make_word(ST_HIT, f, 1'b0, '0, 1'b1));
        return;
      end
      for (int p = FRAMES - 1; p >= 0; p--)
        if (f < 0 && !pool_dirty[pool_order[p]]) f = pool_order[p];
      if (f < 0) begin
        pending_words.push_back(make_word(ST_ALL_DIRTY, 0, 1'b0, '0, 1'b1));
        return;
      end
      pending_words.push_back(make_word(ST_MISS, f, pool_valid[f],
                                        pool_valid[f] ? pool_page[f] : '0, 1'b1));
      pool_page[f] = w.page_id;
      pool_valid[f] = 1'b1;
      pool_dirty[f] = (w.op == OP_INSTALL);
      promote_frame(f);
    end else if (w.op == OP_CKPT) begin
      for (int p = 0; p < FRAMES; p++)
        if (pool_dirty[pool_order[p]])
          pending_words.push_back(make_word(ST_WRITE_BACK, pool_order[p], 1'b0,
                                            pool_page[pool_order[p]], 1'b0));
      for (int i = 0; i < FRAMES; i++) pool_dirty[i] = 1'b0;
      pending_words.push_back(make_word(ST_CKPT_DONE, 0, 1'b0, '0, 1'b1));
    end
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [31:0] pid);
    in_word_t w;
    w.op = op;
    w.page_id = pid;
    while (!gap_free && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pool(w);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_page();
    if (page_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return page_pool[$urandom_range(0, page_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0) @(posedge clk);
    repeat (FRAMES + 4) @(posedge clk);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        out_word_t e;
        e = pending_words.pop_front();
        if (out_word.status !== e.status)
          report_mismatch($sformatf("status %0d want %0d", out_word.status, e.status));
        if (out_word.frame_index !== e.frame_index)
          report_mismatch($sformatf("frame_index %0d want %0d",
                                    out_word.frame_index, e.frame_index));
        if (out_word.evicted_valid !== e.evicted_valid)
          report_mismatch("evicted_valid differs");
        if (out_word.result_page_id !== e.result_page_id)
          report_mismatch($sformatf("result_page_id %h want %h",
                                    out_word.result_page_id, e.result_page_id));
        if (out_word.last !== e.last)
          report_mismatch("last differs");
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("page_frame_lru_with_dirty_pinning verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(OP_READ, 32'h0000_0000);
    send_word(OP_READ, 32'hFFFF_FFFF);
    send_word(OP_READ, 32'h0000_0000);
    send_word(OP_INSTALL, 32'hA5A5_5A5A);
    send_word(OP_INSTALL, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 32'h1234_5678);
    send_word(OP_CKPT, 32'hFFFF_FFFF);
    send_word(OP_CKPT, 32'h0);
  endtask

  task automatic test_all_dirty();
    for (int i = 0; i < FRAMES; i++) send_word(OP_INSTALL, 32'h100 + i);
    send_word(OP_READ, 32'h5555_AAAA);
    send_word(OP_INSTALL, 32'hAAAA_5555);
    send_word(OP_READ, 32'h105);
    send_word(OP_CKPT, 32'h0);
    send_word(OP_READ, 32'h7777_7777);
  endtask

  task automatic test_random(input int count);
    logic [1:0] op;
    int r;
    for (int n = 0; n < count; n++) begin
      gap_free = (n >= count / 3 && n < count / 2);
      r = $urandom_range(0, 99);
      op = (r < 45) ? OP_READ : (r < 88) ? OP_INSTALL : (r < 97) ? OP_CKPT : OP_UNUSED;
      if (op != OP_CKPT) page_pool.push_back($urandom());
      if (page_pool.size() > 24) void'(page_pool.pop_front());
      send_word(op, pick_page());
      if (n == count / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() > 0) @(posedge clk);
      end
    end
    gap_free = 1'b0;
  endtask

  initial begin
    pool_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_all_dirty();
    test_random(440);
    start <= 1'b0;
    wait_drained();
    if (mismatch_count == 0 && pending_words.size() == 0)
      $display("page_frame_lru_with_dirty_pinning verification clean");
    else
      $display("page_frame_lru_with_dirty_pinning verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/pflru_pkg.sv
src/pflru_slot.sv
src/page_frame_lru_with_dirty_pinning.sv
tb/sv/tb_page_frame_lru_with_dirty_pinning.sv
